FILE: hw/rtl/csu_pkg.sv
// csu_pkg: sizes, codes and state type shared by the counting semaphore unit
// no dependencies; used by hw/rtl/counting_semaphore_unit.sv

package csu_pkg;

	localparam int NUM_SEMAPHORES = 8;
	localparam int MAX_THREADS    = 16;

	localparam int SEM_W  = $clog2(NUM_SEMAPHORES);
	localparam int SLOT_W = $clog2(MAX_THREADS);
	// ring size and slot pointers that must hold MAX_THREADS itself
	localparam int RING_W = $clog2(MAX_THREADS + 1);

	localparam int CNT_W  = 8;
	localparam int CMD_W  = 2;
	localparam int ACT_W  = 5;

	localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
	localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};

	localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(MAX_THREADS);

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT   = 2'd0,
		CMD_WAIT   = 2'd1,
		CMD_SIGNAL = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WRAP,
		ST_SEARCH
	} state_t;

	// register addresses on the configuration port
	localparam logic [1:0] ADDR_ACTIVE_THREADS = 2'd0;

endpackage

FILE: hw/rtl/counting_semaphore_unit.sv
// counting_semaphore_unit: semaphore count memory, per-thread block marks and wake-up search
// depends on hw/rtl/csu_pkg.sv
//
// channel   direction  handshake                 payload
// command   in         start & !busy             command, sem_index, init_value, current_thread
// result    out        done (one cycle)          count_after, switch_request, woke_valid,
//                                                woke_thread, no_waiter_error
// config    in/out     psel & penable & pwrite   paddr, pwdata / prdata (active_threads at 0)
//
// init, wait and a signal that needs no wake-up: registered count memory read at accept, then
// the update and write back, then the registered result strobe
// a signal that must wake a thread adds the start-slot wrap (one subtraction of the ring size
// per cycle) plus a one-slot-per-cycle walk of the mark memory, at most ring size slots
// reset clears all counts at once through valid bits and the block flags in their flops; no clearing pass
// busy is high from accept until the result strobe; results cannot be held off

module counting_semaphore_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        command,
	input  logic [2:0]                        sem_index,
	input  logic signed [7:0]                 init_value,
	input  logic [3:0]                        current_thread,
	output logic                              done,
	output logic signed [7:0]                 count_after,
	output logic                              switch_request,
	output logic                              woke_valid,
	output logic [3:0]                        woke_thread,
	output logic                              no_waiter_error,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [1:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	csu_pkg::state_t state_q, state_d;

	// configuration
	logic [csu_pkg::ACT_W-1:0]  active_q;
	logic [csu_pkg::RING_W-1:0] ring_n;

	// captured command
	csu_pkg::cmd_t                     cmd_q;
	logic [csu_pkg::SEM_W-1:0]         sem_q;
	logic signed [csu_pkg::CNT_W-1:0]  ival_q;
	logic [csu_pkg::SLOT_W-1:0]        cur_q;

	// count memory with reset valid bits
	logic signed [csu_pkg::CNT_W-1:0]  sem_mem [csu_pkg::NUM_SEMAPHORES];
	logic signed [csu_pkg::CNT_W-1:0]  sem_rd_s1;
	logic [csu_pkg::NUM_SEMAPHORES-1:0] sem_vld_q;

	// block marks: flag per slot in flops, semaphore index in memory
	logic [csu_pkg::SEM_W-1:0]         mark_mem [csu_pkg::MAX_THREADS];
	logic [csu_pkg::SEM_W-1:0]         mark_rd_s1;
	logic [csu_pkg::MAX_THREADS-1:0]   blocked_q;

	// search
	logic [csu_pkg::RING_W-1:0]        ptr_q;
	logic [csu_pkg::RING_W-1:0]        iss_q;
	logic [csu_pkg::RING_W-1:0]        ptr_inc;
	logic                              issue;
	logic                              chk_vld_s1;
	logic [csu_pkg::SLOT_W-1:0]        chk_slot_s1;
	logic                              chk_last_s1;
	logic                              hit;
	logic signed [csu_pkg::CNT_W-1:0]  cnt_q;

	// update datapath
	logic signed [csu_pkg::CNT_W-1:0]  c_cur, c_new;
	logic                              do_block;
	logic                              need_wake;

	// finish controls
	logic fin, fin_sw, fin_wv, fin_err;

	logic cfg_wr;

	// result registers
	logic                              done_q;
	logic signed [csu_pkg::CNT_W-1:0]  count_after_q;
	logic                              switch_q;
	logic                              woke_vld_q;
	logic [csu_pkg::SLOT_W-1:0]        woke_thr_q;
	logic                              err_q;

	assign busy            = (state_q != csu_pkg::ST_IDLE);
	assign done            = done_q;
	assign count_after     = count_after_q;
	assign switch_request  = switch_q;
	assign woke_valid      = woke_vld_q;
	assign woke_thread     = woke_thr_q;
	assign no_waiter_error = err_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == csu_pkg::ADDR_ACTIVE_THREADS);
	assign prdata = (paddr == csu_pkg::ADDR_ACTIVE_THREADS) ?
		{{(32-csu_pkg::ACT_W){1'b0}}, active_q} : 32'd0;

	// ring size: zero acts as one, above the slot count clamps
	always_comb begin
		if (active_q == '0) begin
			ring_n = csu_pkg::RING_W'(1);
		end else if (csu_pkg::RING_W'(active_q) > csu_pkg::RING_W'(csu_pkg::MAX_THREADS)) begin
			ring_n = csu_pkg::RING_W'(csu_pkg::MAX_THREADS);
		end else begin
			ring_n = csu_pkg::RING_W'(active_q);
		end
	end

	// count update from the registered memory read
	always_comb begin
		c_cur     = sem_vld_q[sem_q] ? sem_rd_s1 : '0;
		c_new     = c_cur;
		do_block  = 1'b0;
		need_wake = 1'b0;
		case (cmd_q)
			csu_pkg::CMD_INIT: begin
				c_new = ival_q;
			end
			csu_pkg::CMD_WAIT: begin
				if (c_cur != csu_pkg::CNT_MIN) begin
					c_new = c_cur - csu_pkg::CNT_W'(1);
				end
				do_block = c_new[csu_pkg::CNT_W-1];
			end
			csu_pkg::CMD_SIGNAL: begin
				if (c_cur != csu_pkg::CNT_MAX) begin
					c_new = c_cur + csu_pkg::CNT_W'(1);
				end
				need_wake = c_new[csu_pkg::CNT_W-1] || (c_new == '0);
			end
			default: begin
				c_new = c_cur;
			end
		endcase
	end

	// search step helpers
	assign ptr_inc = ptr_q + csu_pkg::RING_W'(1);
	assign issue   = (state_q == csu_pkg::ST_SEARCH) && (iss_q != ring_n);
	assign hit     = chk_vld_s1 && blocked_q[chk_slot_s1] && (mark_rd_s1 == sem_q);

	// next state and finish controls
	always_comb begin
		state_d = state_q;
		fin     = 1'b0;
		fin_sw  = 1'b0;
		fin_wv  = 1'b0;
		fin_err = 1'b0;
		case (state_q)
			csu_pkg::ST_IDLE: begin
				if (start) begin
					state_d = csu_pkg::ST_READ;
				end
			end
			csu_pkg::ST_READ: begin
				if (need_wake) begin
					state_d = csu_pkg::ST_WRAP;
				end else begin
					fin     = 1'b1;
					fin_sw  = do_block;
					state_d = csu_pkg::ST_IDLE;
				end
			end
			csu_pkg::ST_WRAP: begin
				if (ptr_q < ring_n) begin
					state_d = csu_pkg::ST_SEARCH;
				end
			end
			csu_pkg::ST_SEARCH: begin
				if (hit) begin
					fin     = 1'b1;
					fin_wv  = 1'b1;
					state_d = csu_pkg::ST_IDLE;
				end else if (chk_vld_s1 && chk_last_s1) begin
					fin     = 1'b1;
					fin_err = 1'b1;
					state_d = csu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csu_pkg::ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= csu_pkg::ST_IDLE;
			active_q   <= csu_pkg::ACT_RESET;
			sem_vld_q  <= '0;
			blocked_q  <= '0;
			chk_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			done_q     <= fin;
			chk_vld_s1 <= issue && !fin;
			if (cfg_wr) begin
				active_q <= pwdata[csu_pkg::ACT_W-1:0];
			end
			if (state_q == csu_pkg::ST_READ) begin
				sem_vld_q[sem_q] <= 1'b1;
				if (do_block) begin
					blocked_q[cur_q] <= 1'b1;
				end
			end
			if (hit) begin
				blocked_q[chk_slot_s1] <= 1'b0;
			end
		end
	end

	// count memory
	always_ff @(posedge clk) begin
		if (state_q == csu_pkg::ST_READ) begin
			sem_mem[sem_q] <= c_new;
		end
		sem_rd_s1 <= sem_mem[sem_index[csu_pkg::SEM_W-1:0]];
	end

	// mark memory, read address follows the search pointer
	always_ff @(posedge clk) begin
		if ((state_q == csu_pkg::ST_READ) && do_block) begin
			mark_mem[cur_q] <= sem_q;
		end
		mark_rd_s1 <= mark_mem[ptr_q[csu_pkg::SLOT_W-1:0]];
	end

	// command capture and search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			csu_pkg::ST_IDLE: begin
				if (start) begin
					cmd_q  <= csu_pkg::cmd_t'(command);
					sem_q  <= sem_index[csu_pkg::SEM_W-1:0];
					ival_q <= init_value;
					cur_q  <= current_thread[csu_pkg::SLOT_W-1:0];
				end
			end
			csu_pkg::ST_READ: begin
				cnt_q <= c_new;
				ptr_q <= csu_pkg::RING_W'(cur_q) + csu_pkg::RING_W'(1);
				iss_q <= '0;
			end
			csu_pkg::ST_WRAP: begin
				// start slot modulo ring size, one subtraction a cycle
				if (ptr_q >= ring_n) begin
					ptr_q <= ptr_q - ring_n;
				end
			end
			csu_pkg::ST_SEARCH: begin
				if (issue) begin
					chk_slot_s1 <= ptr_q[csu_pkg::SLOT_W-1:0];
					chk_last_s1 <= (iss_q == ring_n - csu_pkg::RING_W'(1));
					ptr_q       <= (ptr_inc == ring_n) ? '0 : ptr_inc;
					iss_q       <= iss_q + csu_pkg::RING_W'(1);
				end
			end
			default: begin
				ptr_q <= ptr_q;
			end
		endcase
	end

	// result registers
	always_ff @(posedge clk) begin
		if (fin) begin
			count_after_q <= (state_q == csu_pkg::ST_READ) ? c_new : cnt_q;
			switch_q      <= fin_sw;
			woke_vld_q    <= fin_wv;
			woke_thr_q    <= fin_wv ? chk_slot_s1 : '0;
			err_q         <= fin_err;
		end
	end

`ifndef SYNTHESIS
	// a result only closes a transaction that was in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q != csu_pkg::ST_IDLE))
		else $error("result strobe without a transaction in flight");

	// an accepted command always starts with the count read
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == csu_pkg::ST_READ))
		else $error("accepted command did not enter the read state");

	// the walk never issues more slots than the ring holds
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == csu_pkg::ST_SEARCH) |-> (iss_q <= ring_n) && (ptr_q < ring_n))
		else $error("search pointer left the ring");

	// a woken thread is a ring slot that was blocked in the cycle before its result strobe
	a_wake_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && fin_wv) |=> done && woke_valid && $past(blocked_q[chk_slot_s1]) &&
			!blocked_q[woke_thread])
		else $error("woken thread was not blocked");

	// wake-up and missing waiter exclude each other and the switch request
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($countones({switch_request, woke_valid, no_waiter_error}) <= 1))
		else $error("conflicting result flags");
`endif

endmodule
